/* design/binary_to_decimal_ascii_top_defines.svh */
// Assertion macros shared by the binary to decimal ASCII converter.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTH
`define B2DA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define B2DA_ASSERT(lbl, clk, rst_n, prop, msg)
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/b2da_pkg.sv */
// Types, constants and the BCD adjust function for the binary to decimal converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned NUM_DIGITS  = 20;
    localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
    localparam int unsigned CHAR_W      = 6;
    localparam int unsigned STEP_W      = $clog2(VALUE_W);
    localparam int unsigned LEFT_W      = $clog2(NUM_DIGITS + 1);
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef logic [BCD_W-1:0] t_bcd_word;

    // add 3 to every digit of 5 or more, ahead of the shift
    function automatic t_bcd_word b2da_adjust(input t_bcd_word w);
        t_bcd_word r;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            r[4*k +: 4] = (w[4*k +: 4] >= 4'd5) ? (w[4*k +: 4] + 4'd3) : w[4*k +: 4];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/b2da_fifo.sv */
// Small register queue between the conversion front and the digit emitter.
// Depends on binary_to_decimal_ascii_top_defines.svh for assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_top_defines.svh"

module b2da_fifo #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned W     = 80
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `B2DA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue overfilled")
    `B2DA_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + CNT_W'(1), "queue count lost a push")

endmodule

`default_nettype wire

/* design/b2da_front.sv */
// Conversion front: accepts a number and runs shift-add-3 over 64 steps into BCD.
// Depends on b2da_pkg and binary_to_decimal_ascii_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_top_defines.svh"

module b2da_front
    import b2da_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_bcd_word               o_bcd
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_PUSH} t_state;

    t_state             r_state;
    logic [VALUE_W-1:0] r_bin;
    t_bcd_word          r_bcd;
    t_bcd_word          adj;
    logic [STEP_W-1:0]  r_step;

    assign adj     = b2da_adjust(r_bcd);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_PUSH);
    assign o_bcd   = r_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_bin   <= i_value;
                        r_bcd   <= '0;
                        r_step  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_bcd  <= {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                    r_bin  <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(VALUE_W - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `B2DA_ASSERT_NEXT(a_run_len, i_clk, i_rst_n, r_state == S_RUN && r_step == STEP_W'(VALUE_W - 1), r_state == S_PUSH, "conversion did not finish after last step")

endmodule

`default_nettype wire

/* design/b2da_back.sv */
// Digit emitter: skips leading zeros, then sends one ASCII digit per beat, MSD first.
// Depends on b2da_pkg and binary_to_decimal_ascii_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_top_defines.svh"

module b2da_back
    import b2da_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_bcd_word   i_bcd,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic             o_last
);

    typedef enum logic [1:0] {S_IDLE, S_SKIP, S_EMIT} t_state;

    t_state            r_state;
    t_bcd_word         r_digits;
    logic [LEFT_W-1:0] r_left;
    logic              r_valid;
    logic [CHAR_W-1:0] r_digit_char;
    logic              r_last;
    logic [3:0]        top;
    logic              out_free;

    assign top          = r_digits[BCD_W-1 -: 4];
    assign out_free     = !r_valid || i_ready;
    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_valid;
    assign o_digit_char = r_digit_char;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            // in S_EMIT the output register is reloaded by the emit arm
            if (r_valid && i_ready && r_state != S_EMIT) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_digits <= i_bcd;
                        r_left   <= LEFT_W'(NUM_DIGITS);
                        r_state  <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (top == 4'd0 && r_left != LEFT_W'(1)) begin
                        r_digits <= {r_digits[BCD_W-5:0], 4'd0};
                        r_left   <= r_left - LEFT_W'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_valid      <= 1'b1;
                        r_digit_char <= ASCII_ZERO + {2'b00, top};
                        r_last       <= (r_left == LEFT_W'(1));
                        r_digits     <= {r_digits[BCD_W-5:0], 4'd0};
                        r_left       <= r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_valid <= r_valid;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `B2DA_ASSERT(a_digit_range, i_clk, i_rst_n, !r_valid || (r_digit_char >= ASCII_ZERO && r_digit_char <= ASCII_NINE), "digit outside 0..9")
    `B2DA_ASSERT(a_left_live, i_clk, i_rst_n, r_state == S_IDLE || r_left != '0, "emitter ran past the last digit")

endmodule

`default_nettype wire

/* design/binary_to_decimal_ascii_top.sv */
// Top level of the 64-bit binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_front, b2da_fifo and b2da_back.
//
//  channel   direction  handshake            beat payload
//  input     in         i_valid / o_ready    i_value (64 b)
//  output    out        o_valid / i_ready    o_digit_char (6 b), o_last
//
// Front: accepts a number in S_IDLE, runs 64 shift-add-3 steps in S_RUN, then holds
// it in S_PUSH until the queue takes it; it takes no new number before that hand-off.
// Back: pops a number in S_IDLE, skips one leading zero per cycle in S_SKIP, then
// sends one beat per digit in S_EMIT while the output is free, then returns to S_IDLE.
// Reset is synchronous, active low, and empties the queue and all control.
// Front and back stall on their own; the queue holds up to QUEUE_DEPTH_P numbers.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [CHAR_W-1:0]       o_digit_char,
    output logic                    o_last
);

    logic      fr_valid, fr_ready;
    t_bcd_word fr_bcd;
    logic      bk_valid, bk_ready;
    t_bcd_word bk_bcd;

    b2da_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_bcd   (fr_bcd)
    );

    b2da_fifo #(
        .DEPTH (QUEUE_DEPTH_P),
        .W     (BCD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  (fr_bcd),
        .o_valid (bk_valid),
        .i_ready (bk_ready),
        .o_data  (bk_bcd)
    );

    b2da_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (bk_valid),
        .o_ready      (bk_ready),
        .i_bcd        (bk_bcd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
